// File: rtl/ifhg_pkg.sv
package ifhg_pkg;

  localparam logic [13:0] MtuReset    = 14'd1500;
  localparam logic [13:0] MtuMin      = 14'd1280;
  localparam logic [13:0] MtuMax      = 14'd9000;
  localparam logic [13:0] HdrLen      = 14'd20;
  localparam logic [15:0] VerIhlTos   = 16'h4501;
  localparam logic [7:0]  TtlVal      = 8'h40;

  typedef enum logic [0:0] {
    CFG_MTU = 1'b0,
    CFG_DF  = 1'b1
  } ifhg_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEND
  } ifhg_state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic emit;
  } ifhg_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic last;
    logic out_free;
  } ifhg_sts_t;

endpackage

// File: rtl/ifhg_ctrl.sv
module ifhg_ctrl
  import ifhg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ifhg_sts_t sts,
  output ifhg_cmd_t cmd
);

  ifhg_state_t state;
  ifhg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!sts.len_zero) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ifhg_datapath.sv
module ifhg_datapath
  import ifhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [7:0]  protocol_number,
  input  logic [15:0] payload_length,
  input  logic [15:0] identification,
  input  ifhg_cmd_t   cmd,
  output ifhg_sts_t   sts,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [15:0] flags_offset_word,
  output logic [13:0] total_length,
  output logic [15:0] header_checksum,
  output logic [15:0] payload_offset,
  output logic [13:0] fragment_size,
  output logic        last_fragment
);

  logic [13:0] mtu;
  logic        dont_fragment;

  logic [31:0] src;
  logic [31:0] dst;
  logic [7:0]  proto;
  logic [15:0] len;
  logic [15:0] ident;
  logic        df;

  logic [13:0] slice;
  logic [15:0] base;
  logic [15:0] done;

  logic [13:0] mtu_clamped;
  logic [18:0] base_sum;
  logic [16:0] base_f1;
  logic [15:0] base_next;

  logic [15:0] rem;
  logic        last;
  logic [13:0] size;
  logic [13:0] tot;
  logic [15:0] fo;
  logic [17:0] frag_sum;
  logic [16:0] frag_f1;
  logic [15:0] frag_fold;

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu           <= MtuReset;
      dont_fragment <= 1'b1;
    end else if (cfg_valid) begin
      unique case (ifhg_cfg_idx_t'(cfg_index))
        CFG_MTU: mtu           <= cfg_data;
        CFG_DF:  dont_fragment <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src   <= source_address;
      dst   <= dest_address;
      proto <= protocol_number;
      len   <= payload_length;
      ident <= identification;
      df    <= dont_fragment;
    end
  end

  always_comb begin
    if (mtu < MtuMin) begin
      mtu_clamped = MtuMin;
    end else if (mtu > MtuMax) begin
      mtu_clamped = MtuMax;
    end else begin
      mtu_clamped = mtu;
    end
    base_sum = 19'(VerIhlTos) + 19'(ident) + 19'({TtlVal, proto})
             + 19'(src[31:16]) + 19'(src[15:0]) + 19'(dst[31:16]) + 19'(dst[15:0]);
    base_f1   = 17'(base_sum[15:0]) + 17'(base_sum[18:16]);
    base_next = base_f1[15:0] + 16'(base_f1[16]);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      slice <= mtu_clamped - HdrLen;
      base  <= base_next;
      done  <= '0;
    end else if (cmd.emit) begin
      done  <= done + 16'(size);
    end
  end

  always_comb begin
    rem  = len - done;
    last = (rem <= 16'(slice));
    size = last ? rem[13:0] : {slice[13:3], 3'b000};
    tot  = HdrLen + size;
    fo   = {1'b0, df, ~last, done[15:3]};
    frag_sum  = 18'(base) + 18'(tot) + 18'(fo);
    frag_f1   = 17'(frag_sum[15:0]) + 17'(frag_sum[17:16]);
    frag_fold = frag_f1[15:0] + 16'(frag_f1[16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      flags_offset_word <= fo;
      total_length      <= tot;
      header_checksum   <= ~frag_fold;
      payload_offset    <= done;
      fragment_size     <= size;
      last_fragment     <= last;
    end
  end

  assign sts.len_zero = (payload_length == '0);
  assign sts.last     = last;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

// File: rtl/ipv4_fragment_header_generator.sv
// Splits one datagram per input transaction into IPv4 fragment headers.
// Input channel: in_valid/in_stall with addresses, protocol, payload length
// and identification; a transaction completes when in_valid is high and
// in_stall is low. The block takes a new datagram only while its sequencer
// is idle, which may overlap with the last header still waiting at the output.
// Output channel: out_valid/out_stall, one transaction per fragment, in
// order, with last_fragment set on the final one. A zero length gives none.
// After the input transaction the sequencer passes through its prep and send
// states, and each header is registered at the output; further headers follow
// one per cycle while the output is not stalled.
// While out_stall is high the output register holds its header and the
// sequencer waits; nothing is lost.
// Configuration: cfg_valid/cfg_ready, always ready; index 0 writes the MTU,
// index 1 the DF bit. Write only while idle.
// Reset clears the sequencer and the output valid, sets the MTU to 1500 and
// the DF bit to one.
module ipv4_fragment_header_generator
  import ifhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [7:0]  protocol_number,
  input  logic [15:0] payload_length,
  input  logic [15:0] identification,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] flags_offset_word,
  output logic [13:0] total_length,
  output logic [15:0] header_checksum,
  output logic [15:0] payload_offset,
  output logic [13:0] fragment_size,
  output logic        last_fragment
);

  ifhg_cmd_t cmd;
  ifhg_sts_t sts;

  assign cfg_ready = 1'b1;

  ifhg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ifhg_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .source_address    (source_address),
    .dest_address      (dest_address),
    .protocol_number   (protocol_number),
    .payload_length    (payload_length),
    .identification    (identification),
    .cmd               (cmd),
    .sts               (sts),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .flags_offset_word (flags_offset_word),
    .total_length      (total_length),
    .header_checksum   (header_checksum),
    .payload_offset    (payload_offset),
    .fragment_size     (fragment_size),
    .last_fragment     (last_fragment)
  );

endmodule

// File: sim/frag_header_checker.sv
module frag_header_checker
  import ifhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [7:0]  protocol_number,
  input  logic [15:0] payload_length,
  input  logic [15:0] identification,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] flags_offset_word,
  input  logic [13:0] total_length,
  input  logic [15:0] header_checksum,
  input  logic [15:0] payload_offset,
  input  logic [13:0] fragment_size,
  input  logic        last_fragment,
  output int          fail_count,
  output int          pending
);

  localparam logic [15:0] DfBit = 16'h4000;
  localparam logic [15:0] MfBit = 16'h2000;
  localparam int MaxFragments = 53;

  typedef struct packed {
    logic [15:0] flags_offset_word;
    logic [13:0] total_length;
    logic [15:0] header_checksum;
    logic [15:0] payload_offset;
    logic [13:0] fragment_size;
    logic        last_fragment;
  } frag_hdr_t;

  frag_hdr_t   frag_hdr_q[$];
  logic [13:0] mtu_reg;
  logic        df_reg;

  function automatic logic [15:0] ip_header_checksum(
    logic [15:0] tot, logic [15:0] id, logic [15:0] fo, logic [7:0] proto,
    logic [31:0] src, logic [31:0] dst);
    logic [31:0] acc;
    acc = VerIhlTos + tot + id + fo + {TtlVal, proto} + src[31:16] + src[15:0]
          + dst[31:16] + dst[15:0];
    acc = acc[15:0] + acc[31:16];
    acc = acc[15:0] + acc[31:16];
    return ~acc[15:0];
  endfunction

  function automatic void predict_fragments(
    logic [31:0] src, logic [31:0] dst, logic [7:0] proto, logic [15:0] len,
    logic [15:0] id);
    int unsigned mtu_eff;
    int unsigned slice;
    int unsigned done;
    int unsigned off8;
    int unsigned size;
    int          count;
    logic        more;
    frag_hdr_t   hdr;
    mtu_eff = mtu_reg;
    if (mtu_eff < MtuMin) mtu_eff = MtuMin;
    if (mtu_eff > MtuMax) mtu_eff = MtuMax;
    slice = mtu_eff - HdrLen;
    done  = 0;
    off8  = 0;
    count = 0;
    while (done < len && count < MaxFragments) begin
      if (len - done <= slice) begin
        size = len - done;
        more = 1'b0;
      end else begin
        size = slice & ~32'd7;
        more = 1'b1;
      end
      hdr.flags_offset_word = (df_reg ? DfBit : 16'h0) | (more ? MfBit : 16'h0)
                              | {3'b000, off8[12:0]};
      hdr.total_length      = 14'(HdrLen + size);
      hdr.header_checksum   = ip_header_checksum(16'(HdrLen + size), id,
                                                 hdr.flags_offset_word, proto, src, dst);
      hdr.payload_offset    = done[15:0];
      hdr.fragment_size     = size[13:0];
      hdr.last_fragment     = !more;
      frag_hdr_q.push_back(hdr);
      done  += size;
      off8  += size / 8;
      count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    frag_hdr_t got;
    frag_hdr_t want;
    if (rst) begin
      frag_hdr_q.delete();
      mtu_reg = MtuReset;
      df_reg  = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{flags_offset_word, total_length, header_checksum, payload_offset,
                fragment_size, last_fragment};
        if (frag_hdr_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected fragment header: fo=%h tl=%0d cs=%h po=%0d fs=%0d last=%0d",
                     got.flags_offset_word, got.total_length, got.header_checksum,
                     got.payload_offset, got.fragment_size, got.last_fragment);
        end else begin
          want = frag_hdr_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("fragment header mismatch at %0t", $realtime);
              $display("  expected fo=%h tl=%0d cs=%h po=%0d fs=%0d last=%0d",
                       want.flags_offset_word, want.total_length, want.header_checksum,
                       want.payload_offset, want.fragment_size, want.last_fragment);
              $display("  actual   fo=%h tl=%0d cs=%h po=%0d fs=%0d last=%0d",
                       got.flags_offset_word, got.total_length, got.header_checksum,
                       got.payload_offset, got.fragment_size, got.last_fragment);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        predict_fragments(source_address, dest_address, protocol_number,
                          payload_length, identification);
      if (cfg_valid && cfg_ready) begin
        case (ifhg_cfg_idx_t'(cfg_index))
          CFG_MTU: mtu_reg = cfg_data;
          CFG_DF:  df_reg  = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = frag_hdr_q.size();
  end

endmodule

// File: sim/tb_top.sv
module tb_top
  import ifhg_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [13:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] source_address = '0;
  logic [31:0] dest_address = '0;
  logic [7:0]  protocol_number = '0;
  logic [15:0] payload_length = '0;
  logic [15:0] identification = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] flags_offset_word;
  logic [13:0] total_length;
  logic [15:0] header_checksum;
  logic [15:0] payload_offset;
  logic [13:0] fragment_size;
  logic        last_fragment;

  int          fail_count;
  int          pending;
  logic        calm = 1'b0;
  logic [13:0] cur_mtu = MtuReset;
  logic [13:0] mtu_settings [7] = '{14'd1280, 14'd9000, 14'd0, 14'd16383, 14'd1279,
                                    14'd9001, 14'd1500};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ipv4_fragment_header_generator i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .source_address, .dest_address, .protocol_number,
    .payload_length, .identification,
    .out_valid, .out_stall, .flags_offset_word, .total_length, .header_checksum,
    .payload_offset, .fragment_size, .last_fragment
  );

  frag_header_checker i_checker (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .source_address, .dest_address, .protocol_number,
    .payload_length, .identification,
    .out_valid, .out_stall, .flags_offset_word, .total_length, .header_checksum,
    .payload_offset, .fragment_size, .last_fragment,
    .fail_count, .pending
  );

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 13);
  end

  task automatic send_datagram(logic [31:0] src, logic [31:0] dst, logic [7:0] proto,
                               logic [15:0] len, logic [15:0] id);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    source_address  <= src;
    dest_address    <= dst;
    protocol_number <= proto;
    payload_length  <= len;
    identification  <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_random_datagram();
    int unsigned mtu_eff;
    int unsigned slice;
    int unsigned roll;
    logic [15:0] len;
    mtu_eff = cur_mtu;
    if (mtu_eff < MtuMin) mtu_eff = MtuMin;
    if (mtu_eff > MtuMax) mtu_eff = MtuMax;
    slice = mtu_eff - HdrLen;
    roll  = $urandom_range(99);
    if (roll < 8)
      len = '0;
    else if (roll < 40)
      len = 16'($urandom_range(3000, 1));
    else if (roll < 60)
      len = 16'($urandom_range(3) * (slice & ~32'd7) + slice + $urandom_range(4) - 2);
    else if (roll < 70)
      len = 16'($urandom_range(65535, 65500));
    else
      len = 16'($urandom());
    send_datagram($urandom(), $urandom(), 8'($urandom()), len, 16'($urandom()));
  endtask

  // A zero-length datagram never takes the block out of idle, so the block is idle
  // once the checker's queue is empty; wait for that before touching a register.
  task automatic write_register(ifhg_cfg_idx_t idx, logic [13:0] value);
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MTU) cur_mtu = value;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    send_datagram('0, '0, 8'h00, 16'd0, 16'h0000);
    send_datagram('1, '1, 8'hff, 16'd1, 16'hffff);
    send_datagram(32'hc0a80001, 32'h0a000001, 8'h11, 16'd7, 16'h1234);
    send_datagram(32'h7f000001, 32'hffffffff, 8'h06, 16'd8, 16'h8000);
    send_datagram(32'h01020304, 32'h05060708, 8'h01, 16'd1480, 16'h0001);
    send_datagram(32'hfffffffe, 32'h00000001, 8'h2f, 16'd1481, 16'hfffe);
    send_datagram(32'h80000000, 32'h00008000, 8'h80, 16'd2960, 16'h5555);
    send_datagram(32'h00000001, 32'h80000000, 8'h7f, 16'd2961, 16'haaaa);
    send_datagram('1, '0, 8'hff, 16'd65515, 16'h0000);
    send_datagram('0, '1, 8'h00, 16'd65516, 16'hffff);
    send_datagram('1, '1, 8'hff, 16'd65535, 16'hffff);
    release_input();

    write_register(CFG_MTU, 14'd1283);
    write_register(CFG_DF, 14'd0);
    send_datagram(32'h0a0b0c0d, 32'hd0c0b0a0, 8'h11, 16'd1263, 16'h0102);
    send_datagram(32'h0a0b0c0d, 32'hd0c0b0a0, 8'h11, 16'd1264, 16'h0203);
    send_datagram(32'h0a0b0c0d, 32'hd0c0b0a0, 8'h11, 16'd2519, 16'h0304);
    send_datagram(32'h0a0b0c0d, 32'hd0c0b0a0, 8'h11, 16'd2520, 16'h0405);
    send_datagram(32'h0a0b0c0d, 32'hd0c0b0a0, 8'h11, 16'd2521, 16'h0506);
    send_datagram('1, '1, 8'hff, 16'd65535, 16'hffff);
    release_input();

    for (int p = 0; p < 11; p++) begin
      if (p < 7)
        write_register(CFG_MTU, mtu_settings[p]);
      else if (p == 10)
        write_register(CFG_MTU, 14'($urandom_range(16383)));
      else
        write_register(CFG_MTU, 14'($urandom_range(MtuMax, MtuMin)));
      write_register(CFG_DF, 14'(p % 2));
      calm = (p == 3 || p == 4);
      repeat (8) send_random_datagram();
      release_input();
      calm = 1'b0;
    end

    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (fail_count == 0)
      $display("ipv4_fragment_header_generator verification clean");
    else
      $display("ipv4_fragment_header_generator verification failed");
    $finish;
  end

  initial begin
    #3200000;
    $display("ipv4_fragment_header_generator verification failed");
    $finish;
  end

endmodule
